/* rtl/core/prq_pkg.sv */
// Shared types and constants for the priority run queue.
`default_nettype none
package prq_pkg;

   // Field widths fixed by the item format
   localparam int TASK_W   = 8;
   localparam int PRIO_W   = 8;
   localparam int QCOUNT_W = 5;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;

   // Raw opcodes as they arrive on the request channel
   localparam logic [1:0] OPC_ENQUEUE = 2'd0;
   localparam logic [1:0] OPC_DEQUEUE = 2'd1;
   localparam logic [1:0] OPC_PICK    = 2'd2;
   localparam logic [1:0] OPC_TICK    = 2'd3;

   typedef logic [QCOUNT_W-1:0] qcount_type;

   // Request item
   typedef struct packed {
      logic [1:0]        opcode;
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] task_priority;
      logic [PRIO_W-1:0] running_priority;
   } req_type;

   // Result item
   typedef struct packed {
      logic              task_valid;
      logic [TASK_W-1:0] chosen_task;
      logic              resched_request;
      logic [1:0]        status;
      qcount_type        queued_count;
   } rsp_type;

   // Decoded command class handed from front to back
   typedef enum logic [1:0] {
      CMD_ENQUEUE,
      CMD_DEQUEUE,
      CMD_PICK,
      CMD_TICK
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [TASK_W-1:0] task_id;
      logic [PRIO_W-1:0] task_priority;
      logic [PRIO_W-1:0] running_priority;
   } cmd_type;

endpackage
`default_nettype wire

/* rtl/core/prq_front.sv */
// Front end: accepts request items, decodes them and buffers commands.
`default_nettype none
module prq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire prq_pkg::req_type  req_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_pop,
   output prq_pkg::cmd_type       cmd
);

   localparam int CQ_DEPTH = 2;
   localparam int PTR_W    = $clog2(CQ_DEPTH);
   localparam int FILL_W   = $clog2(CQ_DEPTH + 1);

   prq_pkg::cmd_type  entry_ff [CQ_DEPTH];
   prq_pkg::cmd_type  decoded;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;

   // Classify the opcode
   always_comb begin
      decoded.task_id          = req_data.task_id;
      decoded.task_priority    = req_data.task_priority;
      decoded.running_priority = req_data.running_priority;
      unique case (req_data.opcode)
         prq_pkg::OPC_ENQUEUE: decoded.op = prq_pkg::CMD_ENQUEUE;
         prq_pkg::OPC_DEQUEUE: decoded.op = prq_pkg::CMD_DEQUEUE;
         prq_pkg::OPC_PICK:    decoded.op = prq_pkg::CMD_PICK;
         default:              decoded.op = prq_pkg::CMD_TICK;
      endcase
   end

   // Command queue control
   assign req_stall = (fill_ff == FILL_W'(CQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !cmd_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/prq_back.sv */
// Back end: run queue storage, rotating scan engine and result register.
`default_nettype none
module prq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_pop,
   input  wire prq_pkg::cmd_type  cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output prq_pkg::rsp_type       rsp_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIND,
      S_MOVE,
      S_HEAD,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      SH_NONE,
      SH_APPEND,
      SH_ROT,
      SH_DROP,
      SH_PREP
   } shift_type;

   // Queue slots, entry 0 is the head
   logic [prq_pkg::TASK_W-1:0] slot_task_ff [QUEUE_DEPTH];
   logic [prq_pkg::PRIO_W-1:0] slot_prio_ff [QUEUE_DEPTH];
   logic [prq_pkg::TASK_W-1:0] slot_task_in [QUEUE_DEPTH];
   logic [prq_pkg::PRIO_W-1:0] slot_prio_in [QUEUE_DEPTH];

   state_type                  state_ff, state_in;
   prq_pkg::cmd_type           cmd_ff, cmd_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              len_ff, len_in;
   logic [CW-1:0]              step_ff, step_in;
   logic [CW-1:0]              pos_ff, pos_in;
   logic [CW-1:0]              best_idx_ff, best_idx_in;
   logic [prq_pkg::PRIO_W-1:0] best_ff, best_in;
   logic                       any_ff, any_in;
   logic                       found_ff, found_in;
   logic [prq_pkg::TASK_W-1:0] hold_task_ff, hold_task_in;
   logic [prq_pkg::PRIO_W-1:0] hold_prio_ff, hold_prio_in;
   logic [1:0]                 status_ff, status_in;
   logic                       resched_ff, resched_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   prq_pkg::rsp_type           rsp_ff, rsp_in;

   shift_type                  shift;
   logic [CW-1:0]              lenm1;
   logic                       last;
   logic                       has_head;

   assign lenm1     = len_ff - CW'(1);
   assign last      = (step_ff == CW'(1));
   assign has_head  = (count_ff != '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer: each scan step looks at the head, then rotates or drops it
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      found_in     = found_ff;
      hold_task_in = hold_task_ff;
      hold_prio_in = hold_prio_ff;
      status_in    = status_ff;
      resched_in   = resched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      shift        = SH_NONE;
      cmd_pop      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cmd_in     = cmd;
               status_in  = prq_pkg::STATUS_OK;
               resched_in = 1'b0;
               state_in   = S_FINISH;
               unique case (cmd.op)
                  prq_pkg::CMD_ENQUEUE: begin
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        status_in = prq_pkg::STATUS_FULL;
                     end else begin
                        shift    = SH_APPEND;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  prq_pkg::CMD_DEQUEUE: begin
                     if (!has_head) begin
                        status_in = prq_pkg::STATUS_MISSING;
                     end else begin
                        len_in   = count_ff;
                        step_in  = count_ff;
                        found_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  prq_pkg::CMD_PICK: begin
                     state_in = S_FINISH;
                  end
                  prq_pkg::CMD_TICK: begin
                     if (has_head) begin
                        len_in   = count_ff;
                        step_in  = count_ff;
                        pos_in   = '0;
                        best_in  = '0;
                        any_in   = 1'b0;
                        state_in = S_FIND;
                     end
                  end
               endcase
            end
         end

         // Dequeue: drop the first matching head, rotate the rest
         S_SCAN: begin
            if (!found_ff && slot_task_ff[0] == cmd_ff.task_id) begin
               shift    = SH_DROP;
               found_in = 1'b1;
               len_in   = len_ff - CW'(1);
            end else begin
               shift = SH_ROT;
            end
            step_in = step_ff - CW'(1);
            if (last) begin
               state_in = S_FINISH;
               if (found_in) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  status_in = prq_pkg::STATUS_MISSING;
               end
            end
         end

         // Tick pass one: first entry of greatest priority
         S_FIND: begin
            shift = SH_ROT;
            if (slot_prio_ff[0] > best_ff) begin
               best_in     = slot_prio_ff[0];
               best_idx_in = pos_ff;
               any_in      = 1'b1;
            end
            pos_in  = pos_ff + CW'(1);
            step_in = step_ff - CW'(1);
            if (last) begin
               if (any_in && cmd_ff.running_priority < best_in) begin
                  step_in  = count_ff;
                  pos_in   = '0;
                  state_in = S_MOVE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         // Tick pass two: lift the chosen entry out of the ring
         S_MOVE: begin
            if (pos_ff == best_idx_ff) begin
               hold_task_in = slot_task_ff[0];
               hold_prio_in = slot_prio_ff[0];
               shift        = SH_DROP;
               len_in       = len_ff - CW'(1);
            end else begin
               shift = SH_ROT;
            end
            pos_in  = pos_ff + CW'(1);
            step_in = step_ff - CW'(1);
            if (last) begin
               state_in = S_HEAD;
            end
         end

         // Put the lifted entry in front
         S_HEAD: begin
            shift      = SH_PREP;
            len_in     = len_ff + CW'(1);
            resched_in = 1'b1;
            state_in   = S_FINISH;
         end

         // Load the result register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.task_valid      = (cmd_ff.op == prq_pkg::CMD_PICK) && has_head;
               rsp_in.chosen_task     = '0;
               rsp_in.resched_request = resched_ff;
               rsp_in.status          = status_ff;
               rsp_in.queued_count    = prq_pkg::qcount_type'(count_ff);
               if ((cmd_ff.op == prq_pkg::CMD_PICK || cmd_ff.op == prq_pkg::CMD_TICK)
                   && has_head) begin
                  rsp_in.chosen_task = slot_task_ff[0];
               end
               if (cmd_ff.op == prq_pkg::CMD_PICK && !has_head) begin
                  rsp_in.status = prq_pkg::STATUS_MISSING;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Slot update: every entry reads only its neighbours, the head, the hold or the incoming command
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_task_in[i] = slot_task_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
         unique case (shift)
            SH_APPEND: begin
               if (CW'(i) == count_ff) begin
                  slot_task_in[i] = cmd.task_id;
                  slot_prio_in[i] = cmd.task_priority;
               end
            end
            SH_ROT: begin
               if (CW'(i) == lenm1) begin
                  slot_task_in[i] = slot_task_ff[0];
                  slot_prio_in[i] = slot_prio_ff[0];
               end else if (CW'(i) < lenm1) begin
                  slot_task_in[i] = slot_task_ff[(i + 1) % QUEUE_DEPTH];
                  slot_prio_in[i] = slot_prio_ff[(i + 1) % QUEUE_DEPTH];
               end
            end
            SH_DROP: begin
               if (CW'(i) < lenm1) begin
                  slot_task_in[i] = slot_task_ff[(i + 1) % QUEUE_DEPTH];
                  slot_prio_in[i] = slot_prio_ff[(i + 1) % QUEUE_DEPTH];
               end
            end
            SH_PREP: begin
               if (i == 0) begin
                  slot_task_in[i] = hold_task_ff;
                  slot_prio_in[i] = hold_prio_ff;
               end else begin
                  slot_task_in[i] = slot_task_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                  slot_prio_in[i] = slot_prio_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      len_ff       <= len_in;
      step_ff      <= step_in;
      pos_ff       <= pos_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      any_ff       <= any_in;
      found_ff     <= found_in;
      hold_task_ff <= hold_task_in;
      hold_prio_ff <= hold_prio_in;
      status_ff    <= status_in;
      resched_ff   <= resched_in;
      rsp_ff       <= rsp_in;
   end

   // Slot storage, contents only meaningful below the count
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_task_ff[i] <= slot_task_in[i];
         slot_prio_ff[i] <= slot_prio_in[i];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/priority_run_queue.sv */
// Top level of the priority run queue: front decoder and back engine.
//
// Request channel req_*: valid/stall handshake, an item is taken when
// req_valid is high and req_stall low. Each item carries an opcode
// (enqueue, dequeue, pick head, tick) and task fields.
// Result channel rsp_*: one result item per request, in request order,
// held stable in an output register while rsp_stall is high.
// A two-entry command queue sits between the front and the back, so up to
// three further requests are taken while a result waits: one in the engine
// and two in the command queue.
// Steps per item, set by the rotating scan over the queue entries:
//   enqueue, pick:  result register loaded directly
//   dequeue:        one scan step per queued task, none on an empty queue
//   tick:           a find pass (none on an empty queue), plus a lift pass and a head step on a move
// The engine takes one item at a time and loads the result register once it is free;
// the next item starts in the cycle after that load.
// Reset empties the queue and clears all handshake state; slot contents
// are not cleared. When the receiver stalls, the finished result holds in
// the output register, the engine waits, and req_stall rises once the
// command queue is full.
`default_nettype none
module priority_run_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire prq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output prq_pkg::rsp_type       rsp_data
);

   logic             cmd_valid;
   logic             cmd_pop;
   prq_pkg::cmd_type cmd;

   prq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   prq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
